// ----- rtl/core/rgb_to_hue_sat_intensity_top_assert.svh -----
// Assertion macros used by the RGB to hue, saturation and intensity converter.
`ifndef RGB_TO_HUE_SAT_INTENSITY_TOP_ASSERT_SVH
`define RGB_TO_HUE_SAT_INTENSITY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RHSI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RHSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rhsi_pkg.sv -----
// Shared constants and types of the RGB to hue, saturation and intensity converter.
package rhsi_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int CH_W        = 8;
    localparam int LUMA_W      = 24;
    localparam int LUMA_SHIFT  = 16;
    localparam int DEN_W       = 9;
    localparam int INTEN_W     = 16;
    localparam int HUE_OUT_W   = 17;
    localparam int SAT_OUT_W   = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [LUMA_W-1:0] W_RED   = 24'd19595;
    localparam logic [LUMA_W-1:0] W_GREEN = 24'd38470;
    localparam logic [LUMA_W-1:0] W_BLUE  = 24'd7471;

    localparam logic [CFG_IDX_W-1:0] REG_DARK   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] DARK_RESET   = 8'd20;
    localparam logic [CFG_DATA_W-1:0] BRIGHT_RESET = 8'd235;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // Side information that travels alongside the divider lanes.
    typedef struct packed {
        logic [INTEN_W-1:0] inten;
        logic               chrom;
        logic               ovf;
        logic               neg;
        logic [1:0]         sector;
    } side_t;

endpackage

// ----- rtl/core/rhsi_ifs.sv -----
// Valid/ready channel interfaces for pixels, results and configuration writes.
interface rhsi_pix_if;
    import rhsi_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsi_res_if;
    import rhsi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [INTEN_W-1:0]   intensity_q8;
    logic [HUE_OUT_W-1:0] hue_q8;
    logic [SAT_OUT_W-1:0] saturation_q8;
    logic                 chromatic;
    modport source (output valid, output intensity_q8, output hue_q8, output saturation_q8,
                    output chromatic, input ready);
    modport sink (input valid, input intensity_q8, input hue_q8, input saturation_q8,
                  input chromatic, output ready);
endinterface

interface rhsi_cfg_if;
    import rhsi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rhsi_div_pipe.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
module rhsi_div_pipe #(
    parameter int FRAC_BITS = rhsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [FRAC_BITS+8+rhsi_pkg::DEN_W-1:0]        in_num_sat,
    input  logic [rhsi_pkg::DEN_W-1:0]                    in_den_sat,
    input  logic [FRAC_BITS+8+rhsi_pkg::DEN_W-1:0]        in_num_hue,
    input  logic [rhsi_pkg::DEN_W-1:0]                    in_den_hue,
    input  rhsi_pkg::side_t                               in_side,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [FRAC_BITS+7:0]                          out_q_sat,
    output logic [FRAC_BITS+7:0]                          out_q_hue,
    output rhsi_pkg::side_t                               out_side
);
    import rhsi_pkg::*;

    localparam int Q = FRAC_BITS + 8;

    logic             valid_reg   [Q];
    logic [DEN_W-1:0] rem_s_reg   [Q];
    logic [DEN_W-1:0] den_s_reg   [Q];
    logic [Q-1:0]     lo_s_reg    [Q];
    logic [DEN_W-1:0] rem_h_reg   [Q];
    logic [DEN_W-1:0] den_h_reg   [Q];
    logic [Q-1:0]     lo_h_reg    [Q];
    side_t            side_reg    [Q];
    logic [Q:0]       rdy;

    assign rdy[Q]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic             src_valid;
        logic [DEN_W-1:0] rem_s_in;
        logic [DEN_W-1:0] den_s_in;
        logic [Q-1:0]     lo_s_in;
        logic [DEN_W-1:0] rem_h_in;
        logic [DEN_W-1:0] den_h_in;
        logic [Q-1:0]     lo_h_in;
        side_t            side_in;
        logic [DEN_W:0]   t_s;
        logic [DEN_W:0]   t_h;
        logic             ge_s;
        logic             ge_h;
        logic [DEN_W-1:0] rem_s_next;
        logic [DEN_W-1:0] rem_h_next;
        logic [Q-1:0]     lo_s_next;
        logic [Q-1:0]     lo_h_next;

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign rem_s_in  = in_num_sat[Q+DEN_W-1:Q];
            assign lo_s_in   = in_num_sat[Q-1:0];
            assign den_s_in  = in_den_sat;
            assign rem_h_in  = in_num_hue[Q+DEN_W-1:Q];
            assign lo_h_in   = in_num_hue[Q-1:0];
            assign den_h_in  = in_den_hue;
            assign side_in   = in_side;
        end else begin : g_next
            assign src_valid = valid_reg[k-1];
            assign rem_s_in  = rem_s_reg[k-1];
            assign lo_s_in   = lo_s_reg[k-1];
            assign den_s_in  = den_s_reg[k-1];
            assign rem_h_in  = rem_h_reg[k-1];
            assign lo_h_in   = lo_h_reg[k-1];
            assign den_h_in  = den_h_reg[k-1];
            assign side_in   = side_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        // Shift the next numerator bit into the partial remainder and try a subtract.
        assign t_s        = {rem_s_in, lo_s_in[Q-1]};
        assign t_h        = {rem_h_in, lo_h_in[Q-1]};
        assign ge_s       = t_s >= {1'b0, den_s_in};
        assign ge_h       = t_h >= {1'b0, den_h_in};
        assign rem_s_next = ge_s ? DEN_W'(t_s - {1'b0, den_s_in}) : t_s[DEN_W-1:0];
        assign rem_h_next = ge_h ? DEN_W'(t_h - {1'b0, den_h_in}) : t_h[DEN_W-1:0];
        assign lo_s_next  = {lo_s_in[Q-2:0], ge_s};
        assign lo_h_next  = {lo_h_in[Q-2:0], ge_h};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_valid)
            begin
                rem_s_reg[k] <= rem_s_next;
                den_s_reg[k] <= den_s_in;
                lo_s_reg[k]  <= lo_s_next;
                rem_h_reg[k] <= rem_h_next;
                den_h_reg[k] <= den_h_in;
                lo_h_reg[k]  <= lo_h_next;
                side_reg[k]  <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q-1];
    assign out_q_sat = lo_s_reg[Q-1];
    assign out_q_hue = lo_h_reg[Q-1];
    assign out_side  = side_reg[Q-1];

endmodule

// ----- rtl/core/rgb_to_hue_sat_intensity_top.sv -----
// Top level of the RGB to hue, saturation and intensity converter.
//
//   Channel  Role    Payload                                         Accepted when
//   pix      sink    red, green, blue (8 bits each)                  valid && ready
//   cfg      sink    index, data (dark_limit = 0, bright_limit = 1)  valid && ready
//   res      source  intensity_q8, hue_q8, saturation_q8, chromatic  valid && ready
//
// The block accepts one item per clock while res is not stalled. A result passes
// through the input register, stages 1 and 2, the divider stages and the output
// register; the restoring divider produces one quotient bit per stage.
// Reset clears every valid bit and loads the limits with 20 and 235; no clearing pass.
// Each stage holds its item until the next stage can take it, so a stall on res only
// backs up as far as there are full stages, and bubbles are squeezed out on the way.
`include "rgb_to_hue_sat_intensity_top_assert.svh"

module rgb_to_hue_sat_intensity_top #(
    parameter int FRAC_BITS = rhsi_pkg::FRAC_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    rhsi_pix_if.sink    pix,
    rhsi_cfg_if.sink    cfg,
    rhsi_res_if.source  res
);
    import rhsi_pkg::*;

    // Quotient bits per divider lane; covers 255 and 60 degrees in fixed point.
    localparam int Q     = FRAC_BITS + 8;
    localparam int NUM_W = Q + DEN_W;
    // Signed hue width: 360 degrees needs FRAC_BITS + 9 bits, plus a sign bit.
    localparam int HUE_W = FRAC_BITS + 10;

    localparam logic [Q-1:0]     SAT_MAX = Q'(255) << FRAC_BITS;
    localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(120) << FRAC_BITS;
    localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(240) << FRAC_BITS;
    localparam logic [HUE_W-1:0] HUE_360 = HUE_W'(360) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; an index past
    // the register list is dropped.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] dark_limit_reg;
    logic [CFG_DATA_W-1:0] bright_limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_limit_reg   <= DARK_RESET;
            bright_limit_reg <= BRIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DARK:   dark_limit_reg   <= cfg.data;
                REG_BRIGHT: bright_limit_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage ready chain: a stage may load when it is empty or when the
    // stage after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic res_valid_reg;
    logic s0_rdy;
    logic s1_rdy;
    logic s2_rdy;
    logic out_rdy;
    logic div_in_ready;
    logic div_out_valid;

    assign out_rdy   = !res_valid_reg || res.ready;
    assign s2_rdy    = !s2_valid_reg || div_in_ready;
    assign s1_rdy    = !s1_valid_reg || s2_rdy;
    assign s0_rdy    = !s0_valid_reg || s1_rdy;
    assign pix.ready = s0_rdy;

    // ------------------------------------------------------------------
    // Stage 0: input register.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] s0_red_reg;
    logic [CH_W-1:0] s0_green_reg;
    logic [CH_W-1:0] s0_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_rdy)
        begin
            s0_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy && pix.valid)
        begin
            s0_red_reg   <= pix.red;
            s0_green_reg <= pix.green;
            s0_blue_reg  <= pix.blue;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: luma sum at full precision, max, min and the hue sector.
    // The sector follows the order red, then green, then blue on ties.
    // ------------------------------------------------------------------
    logic [LUMA_W-1:0] luma_next;
    logic [CH_W-1:0]   max_next;
    logic [CH_W-1:0]   min_next;
    logic [1:0]        sector_next;
    logic [LUMA_W-1:0] s1_luma_reg;
    logic [CH_W-1:0]   s1_max_reg;
    logic [CH_W-1:0]   s1_min_reg;
    logic [1:0]        s1_sector_reg;
    logic [CH_W-1:0]   s1_red_reg;
    logic [CH_W-1:0]   s1_green_reg;
    logic [CH_W-1:0]   s1_blue_reg;

    always_comb
    begin
        luma_next = LUMA_W'(s0_red_reg) * W_RED + LUMA_W'(s0_green_reg) * W_GREEN
                  + LUMA_W'(s0_blue_reg) * W_BLUE;
        max_next = s0_red_reg;
        min_next = s0_red_reg;
        if (s0_green_reg > max_next)
        begin
            max_next = s0_green_reg;
        end
        if (s0_blue_reg > max_next)
        begin
            max_next = s0_blue_reg;
        end
        if (s0_green_reg < min_next)
        begin
            min_next = s0_green_reg;
        end
        if (s0_blue_reg < min_next)
        begin
            min_next = s0_blue_reg;
        end
        if (s0_red_reg == max_next)
        begin
            sector_next = SEC_RED;
        end
        else if (s0_green_reg == max_next)
        begin
            sector_next = SEC_GREEN;
        end
        else
        begin
            sector_next = SEC_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_rdy)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && s0_valid_reg)
        begin
            s1_luma_reg   <= luma_next;
            s1_max_reg    <= max_next;
            s1_min_reg    <= min_next;
            s1_sector_reg <= sector_next;
            s1_red_reg    <= s0_red_reg;
            s1_green_reg  <= s0_green_reg;
            s1_blue_reg   <= s0_blue_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: achromatic test, divisor choice for saturation, and the
    // signed channel difference for the hue sector.
    //
    // In the light half the saturation quotient can run past 255. That
    // happens exactly when 255*d >= 256*den, which is flagged here so the
    // divider only ever has to produce Q quotient bits.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  diff;
    logic [DEN_W-1:0] sum;
    logic             light;
    logic [DEN_W-1:0] den_sat_next;
    logic [15:0]      d255;
    logic [CH_W-1:0]  op_a;
    logic [CH_W-1:0]  op_b;
    logic [CH_W-1:0]  mag;
    logic [13:0]      m60;
    logic [NUM_W-1:0] num_sat_next;
    logic [NUM_W-1:0] num_hue_next;
    side_t            side_next;
    logic [NUM_W-1:0] s2_num_sat_reg;
    logic [DEN_W-1:0] s2_den_sat_reg;
    logic [NUM_W-1:0] s2_num_hue_reg;
    logic [DEN_W-1:0] s2_den_hue_reg;
    side_t            s2_side_reg;

    always_comb
    begin
        diff         = s1_max_reg - s1_min_reg;
        sum          = DEN_W'(s1_max_reg) + DEN_W'(s1_min_reg);
        light        = sum > DEN_W'(254);
        den_sat_next = light ? DEN_W'(10'd512 - 10'(sum)) : sum;
        d255         = 16'(diff) * 16'd255;
        num_sat_next = NUM_W'(d255) << FRAC_BITS;

        case (s1_sector_reg)
            SEC_RED:
            begin
                op_a = s1_green_reg;
                op_b = s1_blue_reg;
            end
            SEC_GREEN:
            begin
                op_a = s1_blue_reg;
                op_b = s1_red_reg;
            end
            default:
            begin
                op_a = s1_red_reg;
                op_b = s1_green_reg;
            end
        endcase
        mag          = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
        m60          = 14'(mag) * 14'd60;
        num_hue_next = NUM_W'(m60) << FRAC_BITS;

        side_next.inten  = INTEN_W'(s1_luma_reg >> (LUMA_SHIFT - FRAC_BITS));
        side_next.chrom  = !((s1_max_reg == s1_min_reg)
                          || (s1_luma_reg < {dark_limit_reg, 16'd0})
                          || (s1_luma_reg > {bright_limit_reg, 16'd0}));
        side_next.ovf    = light && ({1'b0, d255} >= {den_sat_next, 8'd0});
        side_next.neg    = op_a < op_b;
        side_next.sector = s1_sector_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_rdy)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_num_sat_reg <= num_sat_next;
            s2_den_sat_reg <= den_sat_next;
            s2_num_hue_reg <= num_hue_next;
            s2_den_hue_reg <= DEN_W'(diff);
            s2_side_reg    <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: saturation and hue offset quotients, Q stages.
    // ------------------------------------------------------------------
    logic [Q-1:0] div_q_sat;
    logic [Q-1:0] div_q_hue;
    side_t        div_side;

    rhsi_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid_reg),
        .in_ready   (div_in_ready),
        .in_num_sat (s2_num_sat_reg),
        .in_den_sat (s2_den_sat_reg),
        .in_num_hue (s2_num_hue_reg),
        .in_den_hue (s2_den_hue_reg),
        .in_side    (s2_side_reg),
        .out_valid  (div_out_valid),
        .out_ready  (out_rdy),
        .out_q_sat  (div_q_sat),
        .out_q_hue  (div_q_hue),
        .out_side   (div_side)
    );

    // ------------------------------------------------------------------
    // Output stage: sector base plus or minus the offset, wrap of a
    // negative hue by 360 degrees, saturation clamp, and zeroing of
    // achromatic pixels.
    // ------------------------------------------------------------------
    logic [HUE_W-1:0]     hue_base;
    logic [HUE_W-1:0]     hue_off;
    logic [HUE_W-1:0]     hue_sum;
    logic [HUE_W-1:0]     hue_wrap;
    logic [Q-1:0]         sat_clamp;
    logic [HUE_OUT_W-1:0] hue_next;
    logic [SAT_OUT_W-1:0] sat_next;
    logic [INTEN_W-1:0]   res_inten_reg;
    logic [HUE_OUT_W-1:0] res_hue_reg;
    logic [SAT_OUT_W-1:0] res_sat_reg;
    logic                 res_chrom_reg;

    always_comb
    begin
        case (div_side.sector)
            SEC_RED:   hue_base = '0;
            SEC_GREEN: hue_base = HUE_120;
            SEC_BLUE:  hue_base = HUE_240;
            default:   hue_base = '0;
        endcase
        hue_off  = HUE_W'(div_q_hue);
        hue_sum  = div_side.neg ? (hue_base - hue_off) : (hue_base + hue_off);
        hue_wrap = hue_sum[HUE_W-1] ? (hue_sum + HUE_360) : hue_sum;

        if (div_side.ovf || (div_q_sat > SAT_MAX))
        begin
            sat_clamp = SAT_MAX;
        end
        else
        begin
            sat_clamp = div_q_sat;
        end

        hue_next = div_side.chrom ? HUE_OUT_W'(hue_wrap) : '0;
        sat_next = div_side.chrom ? SAT_OUT_W'(sat_clamp) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            res_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_out_valid)
        begin
            res_inten_reg <= div_side.inten;
            res_hue_reg   <= hue_next;
            res_sat_reg   <= sat_next;
            res_chrom_reg <= div_side.chrom;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.intensity_q8  = res_inten_reg;
    assign res.hue_q8        = res_hue_reg;
    assign res.saturation_q8 = res_sat_reg;
    assign res.chromatic     = res_chrom_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RHSI_ASSERT_IMPL(a_achrom_zero, res.valid && !res.chromatic,
                      (res.hue_q8 == '0) && (res.saturation_q8 == '0),
                      "achromatic result carries nonzero hue or saturation")
    `RHSI_ASSERT_NEXT(a_in_lands, pix.valid && pix.ready, s0_valid_reg,
                      "accepted pixel did not land in the input stage")
    `RHSI_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !div_in_ready, s2_valid_reg,
                      "stalled item dropped out of stage two")
    `RHSI_ASSERT_NEXT(a_out_load, div_out_valid && out_rdy, res_valid_reg,
                      "divider result was not loaded into the output register")

endmodule

// ----- test/rgb_to_hue_sat_intensity_top_tb.sv -----
// Self-checking testbench for the RGB to hue, saturation and intensity converter.
`timescale 1ns / 1ps

module rgb_to_hue_sat_intensity_top_tb;
    import rhsi_pkg::*;

    // Fractional bits of the block as built, and its latency from pixel to result.
    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = FB + 11;

    // Luma weights as plain integers, so the prediction never mixes in unsigned math.
    localparam longint LUMA_R = W_RED;
    localparam longint LUMA_G = W_GREEN;
    localparam longint LUMA_B = W_BLUE;

    // Register indexes above the two limits are ignored by the block.
    localparam int SPARE_IDX_LO = REG_BRIGHT + 1;
    localparam int SPARE_IDX_HI = (1 << CFG_IDX_W) - 1;

    localparam int PHASES = 10;
    localparam int PIXELS_PER_PHASE = 185;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [INTEN_W-1:0]   inten;
        logic [HUE_OUT_W-1:0] hue;
        logic [SAT_OUT_W-1:0] sat;
        logic                 chrom;
    } hsi_t;

    // An expected result together with the pixel it came from, for readable reports.
    typedef struct {
        pixel_t px;
        hsi_t   val;
    } pending_hsi_t;

    // Hand-picked pixels for the directed part, all under the reset limits.
    localparam pixel_t CORNER_PIXELS [18] = '{
        {8'd0,   8'd0,   8'd0},     // black, gray
        {8'd255, 8'd255, 8'd255},   // white, gray
        {8'd128, 8'd128, 8'd128},   // mid gray
        {8'd255, 8'd0,   8'd0},     // pure red, light half
        {8'd0,   8'd255, 8'd0},     // pure green
        {8'd0,   8'd0,   8'd255},   // pure blue, just above the dark limit
        {8'd100, 8'd50,  8'd20},    // dark half
        {8'd200, 8'd54,  8'd100},   // max + min exactly 254
        {8'd200, 8'd55,  8'd100},   // max + min exactly 255
        {8'd200, 8'd50,  8'd100},   // red sector with a negative hue
        {8'd50,  8'd200, 8'd100},   // green sector
        {8'd50,  8'd100, 8'd200},   // blue sector
        {8'd200, 8'd200, 8'd50},    // red and green tie for max
        {8'd50,  8'd200, 8'd200},   // green and blue tie for max
        {8'd200, 8'd50,  8'd200},   // red and blue tie, negative hue
        {8'd255, 8'd1,   8'd0},     // widest light-half saturation
        {8'd10,  8'd10,  8'd11},    // colored but below the dark limit
        {8'd255, 8'd254, 8'd255}    // colored but above the bright limit
    };

    // The scoreboard keeps its own copy of the two limits, predicts each pixel as it
    // is accepted, and checks results in order against the oldest prediction.
    class hsi_scoreboard;
        pending_hsi_t     pending_q[$];
        logic [CH_W-1:0]  dark_level   = DARK_RESET;
        logic [CH_W-1:0]  bright_level = BRIGHT_RESET;
        int               errors;
        int               pixels_seen;
        int               colored_seen;

        function void write_limit(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == REG_DARK)
                dark_level = value;
            else if (index == REG_BRIGHT)
                bright_level = value;
        endfunction

        // 60 * num / den degrees with FB fractional bits, truncated toward zero.
        function longint sector_angle(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = ((60 * mag) << FB) / den;
            return (num < 0) ? -q : q;
        endfunction

        function hsi_t convert(pixel_t p);
            longint r, g, b, mx, mn, d, total, luma, top, sat, hue;
            hsi_t   pred;
            r = longint'(p.red);
            g = longint'(p.green);
            b = longint'(p.blue);
            luma = r * LUMA_R + g * LUMA_G + b * LUMA_B;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            pred.inten = INTEN_W'(luma >> (LUMA_SHIFT - FB));
            pred.hue = '0;
            pred.sat = '0;
            pred.chrom = 1'b0;
            // The limits compare against the full-precision luma sum.
            if (mx != mn && luma >= (longint'(dark_level) << LUMA_SHIFT) &&
                luma <= (longint'(bright_level) << LUMA_SHIFT))
            begin
                d = mx - mn;
                total = mx + mn;
                top = (255 * d) << FB;
                if (total <= 254)
                    sat = top / total;
                else
                    sat = top / (512 - total);
                if (sat > (255 << FB))
                    sat = 255 << FB;
                if (r == mx)
                    hue = sector_angle(g - b, d);
                else if (g == mx)
                    hue = (120 << FB) + sector_angle(b - r, d);
                else
                    hue = (240 << FB) + sector_angle(r - g, d);
                if (hue < 0)
                    hue += 360 << FB;
                pred.hue = HUE_OUT_W'(hue);
                pred.sat = SAT_OUT_W'(sat);
                pred.chrom = 1'b1;
            end
            return pred;
        endfunction

        function void note_pixel(pixel_t p);
            pending_hsi_t e;
            e.px = p;
            e.val = convert(p);
            pending_q.insert(pending_q.size(), e);
            pixels_seen++;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Printing is capped so a badly broken block cannot flood the log.
        task report_mismatch(string msg);
            if (errors < 40)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(hsi_t got);
            pending_hsi_t e;
            string        tag;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("result %p arrived with no pixel pending", got));
                return;
            end
            e = pending_q.pop_front();
            tag = $sformatf("rgb (%0d,%0d,%0d)", e.px.red, e.px.green, e.px.blue);
            if (got.inten !== e.val.inten)
                report_mismatch($sformatf("%s intensity %0d, want %0d", tag, got.inten,
                                          e.val.inten));
            if (got.hue !== e.val.hue)
                report_mismatch($sformatf("%s hue %0d, want %0d", tag, got.hue, e.val.hue));
            if (got.sat !== e.val.sat)
                report_mismatch($sformatf("%s saturation %0d, want %0d", tag, got.sat,
                                          e.val.sat));
            if (got.chrom !== e.val.chrom)
                report_mismatch($sformatf("%s chromatic %b, want %b", tag, got.chrom,
                                          e.val.chrom));
            if (e.val.chrom)
                colored_seen++;
        endtask

        // Anything still pending once the pipeline has had time to empty is lost.
        task flush_missing();
            pending_hsi_t e;
            while (pending_q.size() != 0)
            begin
                e = pending_q.pop_front();
                report_mismatch($sformatf("no result for rgb (%0d,%0d,%0d)", e.px.red,
                                          e.px.green, e.px.blue));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rhsi_pix_if pix ();
    rhsi_cfg_if cfg ();
    rhsi_res_if res ();

    hsi_scoreboard sb = new;

    // Idle enables for the pixel source and the result sink; changed in chunks so the
    // run gets stretches with gaps, stretches with stalls, and clean stretches.
    bit src_idle;
    bit sink_idle;
    int reg_writes;
    int limit_settings;

    rgb_to_hue_sat_intensity_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .res   (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Results are checked at the clock edge where the handshake completes. All inputs
    // of the block change only through nonblocking assignments, so the values read
    // here are the ones the block itself saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_result({res.intensity_q8, res.hue_q8, res.saturation_q8, res.chromatic});
    end

    // Result sink: ready drops in bursts of random length while stalls are on.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_idle && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                res.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // Looks for a colored pixel whose luma sum sits exactly on an integer level, so
    // that the limit comparison is hit at its boundary. Falls back to gray.
    function automatic pixel_t pixel_at_level(input logic [CH_W-1:0] level);
        longint rest;
        int     r0, g0, r, g, b;
        pixel_t p;
        r0 = $urandom_range(0, 255);
        g0 = $urandom_range(0, 255);
        p = {level, level, level};
        for (int i = 0; i < 65536; i++)
        begin
            r = (r0 + i) % 256;
            g = (g0 + i / 256) % 256;
            rest = (longint'(level) << LUMA_SHIFT) - r * LUMA_R - g * LUMA_G;
            if (rest >= 0 && rest % LUMA_B == 0 && rest / LUMA_B <= 255)
            begin
                b = int'(rest / LUMA_B);
                if (!(r == g && g == b))
                begin
                    p = {r[7:0], g[7:0], b[7:0]};
                    return p;
                end
            end
        end
        return p;
    endfunction

    // Random pixels, weighted toward the awkward ones: near-gray, ties for the maximum,
    // saturated channels and pixels sitting right on one of the current limits.
    function automatic pixel_t random_pixel();
        int     ch [3];
        int     base, v, w;
        pixel_t p;
        case ($urandom_range(0, 9))
            0:
            begin
                base = $urandom_range(0, 255);
                foreach (ch[k])
                begin
                    ch[k] = base + int'($urandom_range(0, 6)) - 3;
                    if (ch[k] < 0)
                        ch[k] = 0;
                    else if (ch[k] > 255)
                        ch[k] = 255;
                end
                p = {ch[0][7:0], ch[1][7:0], ch[2][7:0]};
            end
            1:
            begin
                v = $urandom_range(0, 255);
                w = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0: p = {v[7:0], v[7:0], w[7:0]};
                    1: p = {v[7:0], w[7:0], v[7:0]};
                    default: p = {w[7:0], v[7:0], v[7:0]};
                endcase
            end
            2:
            begin
                foreach (ch[k])
                begin
                    if ($urandom_range(0, 2) == 0)
                        ch[k] = 0;
                    else if ($urandom_range(0, 1) == 0)
                        ch[k] = 255;
                    else
                        ch[k] = $urandom_range(0, 255);
                end
                p = {ch[0][7:0], ch[1][7:0], ch[2][7:0]};
            end
            3: p = pixel_at_level($urandom_range(0, 1) ? sb.dark_level : sb.bright_level);
            default:
            begin
                p.red = CH_W'($urandom_range(0, 255));
                p.green = CH_W'($urandom_range(0, 255));
                p.blue = CH_W'($urandom_range(0, 255));
            end
        endcase
        return p;
    endfunction

    // Offers one pixel, possibly after a short gap, and returns at the edge where it
    // is accepted. Valid stays high into the next call when there is no gap.
    task automatic send_pixel(input pixel_t p);
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.red <= p.red;
        pix.green <= p.green;
        pix.blue <= p.blue;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    // One register write; the caller lowers valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_limit(index, value);
        reg_writes++;
    endtask

    // Loads both limits, on some calls with a write to an unused index in between that
    // must not disturb either of them.
    task automatic set_limits(input logic [CFG_DATA_W-1:0] dark,
                              input logic [CFG_DATA_W-1:0] bright);
        write_reg(REG_DARK, dark);
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)),
                      CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_BRIGHT, bright);
        cfg.valid <= 1'b0;
        limit_settings++;
    endtask

    task automatic run_pixels(input int count, input bit quiet);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                src_idle = !quiet && ($urandom_range(0, 1) == 1);
                sink_idle = !quiet && ($urandom_range(0, 1) == 1);
            end
            send_pixel(random_pixel());
        end
        pix.valid <= 1'b0;
    endtask

    // Waits, with a bound, for every pending result, then lets the pipeline run on past
    // its latency so a stray extra result would still be caught.
    task automatic drain_results();
        for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        sb.flush_missing();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        pix.valid <= 1'b0;
        pix.red <= '0;
        pix.green <= '0;
        pix.blue <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limits, then two pixels sitting exactly on
        // the dark and the bright limit, which must still count as colored.
        src_idle = 1'b1;
        sink_idle = 1'b1;
        foreach (CORNER_PIXELS[k])
            send_pixel(CORNER_PIXELS[k]);
        send_pixel(pixel_at_level(DARK_RESET));
        send_pixel(pixel_at_level(BRIGHT_RESET));
        pix.valid <= 1'b0;
        drain_results();

        // Random phases, each under its own pair of limits, extremes in even phases
        // below eight; the final phase runs with no gaps and no stalls at all.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_limits(8'd0, 8'd255);
                2: set_limits(8'd255, 8'd0);
                4: set_limits(8'd0, 8'd0);
                6: set_limits(8'd255, 8'd255);
                8: set_limits(DARK_RESET, BRIGHT_RESET);
                default: set_limits(CFG_DATA_W'($urandom_range(0, 120)),
                                    CFG_DATA_W'($urandom_range(130, 255)));
            endcase
            run_pixels(PIXELS_PER_PHASE, ph == PHASES - 1);
            drain_results();
        end

        $display("Converted %0d pixels, %0d of them colored, under %0d limit settings.",
                 sb.pixels_seen, sb.colored_seen, limit_settings);
        $display("Register writes: %0d, mismatches: %0d.", reg_writes, sb.errors);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #5ms;
        $display("Timeout with %0d results still pending.", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rhsi_pkg.sv
rtl/core/rhsi_ifs.sv
rtl/core/rhsi_div_pipe.sv
rtl/core/rgb_to_hue_sat_intensity_top.sv
test/rgb_to_hue_sat_intensity_top_tb.sv
